// ===== hdl/rre_pkg.sv =====
// ----------------------------------------------------------------------------
// rre_pkg
// Shared types, constants and helpers for the RTT / RTO estimator.
// ----------------------------------------------------------------------------
package rre_pkg;

    localparam int TIME_W = 24;
    localparam int GAIN_W = 16;
    localparam int CNT_W  = 8;
    localparam int ACC_W  = 42;
    localparam int WIDE_W = 34;
    localparam int IDX_W  = 3;
    localparam int SEG_W  = 32;

    localparam logic [TIME_W-1:0] TIME_MAX = 24'hFFFFFF;

    localparam logic [TIME_W-1:0] MIN_DQN_INTERVAL = 24'd5120;
    localparam logic [TIME_W-1:0] MAX_DQN_INTERVAL = 24'd256000;
    localparam logic [TIME_W-1:0] MIN_BBR_INTERVAL = 24'd5120;
    localparam logic [TIME_W-1:0] MAX_BBR_INTERVAL = 24'd256000;
    localparam logic [TIME_W-1:0] DQN_RESET        = 24'd5120;

    localparam logic [GAIN_W-1:0] ALPHA_RESET   = 16'd8192;
    localparam logic [GAIN_W-1:0] BETA_RESET    = 16'd16384;
    localparam logic [GAIN_W-1:0] K_RESET       = 16'd1024;
    localparam logic [GAIN_W-1:0] BACKOFF_RESET = 16'd512;
    localparam logic [TIME_W-1:0] FLOOR_RESET   = 24'd51200;
    localparam logic [TIME_W-1:0] CEIL_RESET    = 24'd15360000;
    localparam logic [TIME_W-1:0] START_RESET   = 24'd256000;

    // Register indexes of the configuration port
    localparam logic [IDX_W-1:0] REG_ALPHA   = 3'd0;
    localparam logic [IDX_W-1:0] REG_BETA    = 3'd1;
    localparam logic [IDX_W-1:0] REG_K       = 3'd2;
    localparam logic [IDX_W-1:0] REG_FLOOR   = 3'd3;
    localparam logic [IDX_W-1:0] REG_CEIL    = 3'd4;
    localparam logic [IDX_W-1:0] REG_START   = 3'd5;
    localparam logic [IDX_W-1:0] REG_BACKOFF = 3'd6;

    // Item opcodes
    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_BACKOFF = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_WAIT,
        ST_VAR_GO,
        ST_VAR_WAIT,
        ST_SRTT_GO,
        ST_SRTT_WAIT,
        ST_RTO_GO,
        ST_RTO_WAIT,
        ST_BACK_GO,
        ST_BACK_WAIT,
        ST_FINISH
    } state_t;

    // Command to the serial multiply-accumulate unit
    typedef struct packed {
        logic              start;
        logic [ACC_W-1:0]  acc_init;
        logic [ACC_W-1:0]  mcand;
        logic [GAIN_W-1:0] mult;
    } mac_cmd_t;

    function automatic logic [TIME_W-1:0] sat_time(input logic [WIDE_W-1:0] v);
        logic [TIME_W-1:0] r;
        begin
            if (v[WIDE_W-1:TIME_W] != '0)
                r = TIME_MAX;
            else
                r = v[TIME_W-1:0];
            return r;
        end
    endfunction

    function automatic logic [TIME_W-1:0] clamp_time(
        input logic [TIME_W-1:0] v,
        input logic [TIME_W-1:0] lo,
        input logic [TIME_W-1:0] hi
    );
        logic [TIME_W-1:0] r;
        begin
            if (v < lo)
                r = lo;
            else if (v > hi)
                r = hi;
            else
                r = v;
            return r;
        end
    endfunction

endpackage

// ===== hdl/rtt_rto_estimator.sv =====
// ----------------------------------------------------------------------------
// rtt_rto_estimator
// Jacobson/Karels round-trip and retransmission-timeout estimator.
// ----------------------------------------------------------------------------
// One item is in flight at a time; in_ready is high only while the
// controller is idle, and a finished result waits in the output register
// so the next item can be taken meanwhile. A measurement once a sample
// exists runs two bit-serial divides side by side, then three serial
// multiply passes for rttvar, srtt and rto, each launched from its own
// GO state, then a finish state; the first measurement runs only the rto
// pass and a backoff only the backoff pass. The processing time is set by
// the bit-serial multiply-accumulate unit, which takes one multiplier bit
// per cycle, and the bit-serial dividers that form alpha/n and beta/n.
// Times are Q16.8 ms, results saturate at full scale, and n = 0 is treated
// as n = 1. The config port is always ready; write only while the block
// is idle.
// ----------------------------------------------------------------------------
module rtt_rto_estimator (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration write channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [rre_pkg::IDX_W-1:0]  cfg_index,
    input  logic [rre_pkg::TIME_W-1:0] cfg_data,
    // item input channel
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       op,
    input  logic [rre_pkg::SEG_W-1:0]  seg_number,
    input  logic [rre_pkg::TIME_W-1:0] rtt_sample,
    input  logic [rre_pkg::CNT_W-1:0]  expected_samples,
    // result output channel
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [rre_pkg::SEG_W-1:0]  seg_echo,
    output logic                       is_measurement,
    output logic [rre_pkg::TIME_W-1:0] srtt_out,
    output logic [rre_pkg::TIME_W-1:0] rttvar_out,
    output logic [rre_pkg::TIME_W-1:0] rto_out,
    output logic [rre_pkg::TIME_W-1:0] dqn_interval_out,
    output logic [rre_pkg::TIME_W-1:0] bbr_interval_out
);
    import rre_pkg::*;

    // configuration registers
    logic [GAIN_W-1:0] alpha_reg;
    logic [GAIN_W-1:0] beta_reg;
    logic [GAIN_W-1:0] k_reg;
    logic [TIME_W-1:0] floor_reg;
    logic [TIME_W-1:0] ceil_reg;
    logic [GAIN_W-1:0] backoff_reg;

    // estimator state
    logic [TIME_W-1:0] srtt_reg,   srtt_next;
    logic [TIME_W-1:0] rttvar_reg, rttvar_next;
    logic [TIME_W-1:0] rto_reg,    rto_next;
    logic              have_reg,   have_next;
    logic [TIME_W-1:0] dqn_reg,    dqn_next;
    logic [TIME_W-1:0] bbr_reg,    bbr_next;

    // item being worked on
    state_t            state_reg, state_next;
    logic              op_reg,     op_next;
    logic [SEG_W-1:0]  seg_reg,    seg_next;
    logic [TIME_W-1:0] sample_reg, sample_next;
    logic [TIME_W-1:0] err_reg,    err_next;
    logic [TIME_W-1:0] raw_reg,    raw_next;

    // output register
    logic              ovalid_reg, ovalid_next;
    logic [SEG_W-1:0]  oseg_reg,   oseg_next;
    logic              omeas_reg,  omeas_next;
    logic [TIME_W-1:0] osrtt_reg,  osrtt_next;
    logic [TIME_W-1:0] ovar_reg,   ovar_next;
    logic [TIME_W-1:0] orto_reg,   orto_next;
    logic [TIME_W-1:0] odqn_reg,   odqn_next;
    logic [TIME_W-1:0] obbr_reg,   obbr_next;

    // serial units
    logic              div_start;
    logic [CNT_W-1:0]  n_eff;
    logic [GAIN_W-1:0] a_q;
    logic [GAIN_W-1:0] b_q;
    logic              a_done;
    logic              b_done;
    mac_cmd_t          mac_cmd;
    logic [ACC_W-1:0]  mac_acc;
    logic              mac_done;

    logic              in_xfer;
    logic [TIME_W:0]   diff_var;
    logic [TIME_W:0]   diff_srtt;
    logic [TIME_W-1:0] rto_clamped;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;

    // treat a zero sample count as one
    assign n_eff     = (expected_samples == '0) ? CNT_W'(1) : expected_samples;
    assign div_start = in_xfer && (op == OP_MEASURE) && have_reg;

    rre_serial_div u_div_alpha (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (alpha_reg),
        .divisor  (n_eff),
        .quotient (a_q),
        .done     (a_done)
    );

    rre_serial_div u_div_beta (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (beta_reg),
        .divisor  (n_eff),
        .quotient (b_q),
        .done     (b_done)
    );

    rre_serial_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mac_cmd),
        .acc   (mac_acc),
        .done  (mac_done)
    );

    // signed deltas for the blends: old * 2^16 + g * (target - old)
    assign diff_var  = {1'b0, err_reg}    - {1'b0, rttvar_reg};
    assign diff_srtt = {1'b0, sample_reg} - {1'b0, srtt_reg};

    // operands for the multiply pass launched in each GO state
    always_comb
    begin
        mac_cmd = '0;
        unique case (state_reg)
            ST_VAR_GO:
            begin
                mac_cmd.start    = 1'b1;
                mac_cmd.acc_init = {2'b00, rttvar_reg, 16'h8000};
                mac_cmd.mcand    = {{(ACC_W-TIME_W-1){diff_var[TIME_W]}}, diff_var};
                mac_cmd.mult     = b_q;
            end
            ST_SRTT_GO:
            begin
                mac_cmd.start    = 1'b1;
                mac_cmd.acc_init = {2'b00, srtt_reg, 16'h8000};
                mac_cmd.mcand    = {{(ACC_W-TIME_W-1){diff_srtt[TIME_W]}}, diff_srtt};
                mac_cmd.mult     = a_q;
            end
            ST_RTO_GO:
            begin
                // srtt * 256 + k * rttvar + 128, then drop eight bits
                mac_cmd.start    = 1'b1;
                mac_cmd.acc_init = {10'd0, srtt_reg, 8'h80};
                mac_cmd.mcand    = {{(ACC_W-TIME_W){1'b0}}, rttvar_reg};
                mac_cmd.mult     = k_reg;
            end
            ST_BACK_GO:
            begin
                mac_cmd.start    = 1'b1;
                mac_cmd.acc_init = ACC_W'(128);
                mac_cmd.mcand    = {{(ACC_W-TIME_W){1'b0}}, rto_reg};
                mac_cmd.mult     = backoff_reg;
            end
            default:
            begin
                mac_cmd = '0;
            end
        endcase
    end

    assign rto_clamped = clamp_time(raw_reg, floor_reg, ceil_reg);

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        seg_next    = seg_reg;
        sample_next = sample_reg;
        err_next    = err_reg;
        raw_next    = raw_reg;
        srtt_next   = srtt_reg;
        rttvar_next = rttvar_reg;
        rto_next    = rto_reg;
        have_next   = have_reg;
        dqn_next    = dqn_reg;
        bbr_next    = bbr_reg;
        ovalid_next = ovalid_reg;
        oseg_next   = oseg_reg;
        omeas_next  = omeas_reg;
        osrtt_next  = osrtt_reg;
        ovar_next   = ovar_reg;
        orto_next   = orto_reg;
        odqn_next   = odqn_reg;
        obbr_next   = obbr_reg;

        // drop the result once the consumer takes it
        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next     = op;
                    seg_next    = seg_number;
                    sample_next = rtt_sample;
                    err_next    = (srtt_reg >= rtt_sample) ? srtt_reg - rtt_sample
                                                           : rtt_sample - srtt_reg;
                    if (op == OP_BACKOFF)
                        state_next = ST_BACK_GO;
                    else if (have_reg)
                        state_next = ST_DIV_WAIT;
                    else
                    begin
                        // first sample seeds the estimator directly
                        srtt_next   = rtt_sample;
                        rttvar_next = {1'b0, rtt_sample[TIME_W-1:1]};
                        have_next   = 1'b1;
                        state_next  = ST_RTO_GO;
                    end
                end
            end
            ST_DIV_WAIT:
            begin
                if (a_done && b_done)
                    state_next = ST_VAR_GO;
            end
            ST_VAR_GO:
            begin
                state_next = ST_VAR_WAIT;
            end
            ST_VAR_WAIT:
            begin
                if (mac_done)
                begin
                    rttvar_next = sat_time(WIDE_W'(mac_acc[ACC_W-1:16]));
                    state_next  = ST_SRTT_GO;
                end
            end
            ST_SRTT_GO:
            begin
                state_next = ST_SRTT_WAIT;
            end
            ST_SRTT_WAIT:
            begin
                if (mac_done)
                begin
                    srtt_next  = sat_time(WIDE_W'(mac_acc[ACC_W-1:16]));
                    state_next = ST_RTO_GO;
                end
            end
            ST_RTO_GO:
            begin
                state_next = ST_RTO_WAIT;
            end
            ST_RTO_WAIT:
            begin
                if (mac_done)
                begin
                    raw_next   = sat_time(mac_acc[ACC_W-1:8]);
                    state_next = ST_FINISH;
                end
            end
            ST_BACK_GO:
            begin
                state_next = ST_BACK_WAIT;
            end
            ST_BACK_WAIT:
            begin
                if (mac_done)
                begin
                    raw_next   = sat_time(mac_acc[ACC_W-1:8]);
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // hold until the output register is free
                if (!ovalid_reg || out_ready)
                begin
                    rto_next = rto_clamped;
                    if (op_reg == OP_MEASURE)
                    begin
                        dqn_next = clamp_time(raw_reg, MIN_DQN_INTERVAL, MAX_DQN_INTERVAL);
                        bbr_next = clamp_time(raw_reg, MIN_BBR_INTERVAL, MAX_BBR_INTERVAL);
                    end
                    ovalid_next = 1'b1;
                    oseg_next   = (op_reg == OP_MEASURE) ? seg_reg : '0;
                    omeas_next  = (op_reg == OP_MEASURE);
                    osrtt_next  = srtt_reg;
                    ovar_next   = rttvar_reg;
                    orto_next   = rto_clamped;
                    odqn_next   = dqn_next;
                    obbr_next   = bbr_next;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // before the first sample the start value is the live rto
        if (cfg_valid && cfg_ready && (cfg_index == REG_START) && !have_reg)
            rto_next = cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration registers and estimator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg     <= ALPHA_RESET;
            beta_reg      <= BETA_RESET;
            k_reg         <= K_RESET;
            floor_reg     <= FLOOR_RESET;
            ceil_reg      <= CEIL_RESET;
            backoff_reg   <= BACKOFF_RESET;
            srtt_reg      <= '0;
            rttvar_reg    <= '0;
            rto_reg       <= START_RESET;
            have_reg      <= 1'b0;
            dqn_reg       <= DQN_RESET;
            bbr_reg       <= '0;
            ovalid_reg    <= 1'b0;
        end
        else
        begin
            srtt_reg   <= srtt_next;
            rttvar_reg <= rttvar_next;
            have_reg   <= have_next;
            dqn_reg    <= dqn_next;
            bbr_reg    <= bbr_next;
            ovalid_reg <= ovalid_next;
            rto_reg    <= rto_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_ALPHA:   alpha_reg   <= cfg_data[GAIN_W-1:0];
                    REG_BETA:    beta_reg    <= cfg_data[GAIN_W-1:0];
                    REG_K:       k_reg       <= cfg_data[GAIN_W-1:0];
                    REG_FLOOR:   floor_reg   <= cfg_data;
                    REG_CEIL:    ceil_reg    <= cfg_data;
                    REG_BACKOFF: backoff_reg <= cfg_data[GAIN_W-1:0];
                    default:     ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        seg_reg    <= seg_next;
        sample_reg <= sample_next;
        err_reg    <= err_next;
        raw_reg    <= raw_next;
        oseg_reg   <= oseg_next;
        omeas_reg  <= omeas_next;
        osrtt_reg  <= osrtt_next;
        ovar_reg   <= ovar_next;
        orto_reg   <= orto_next;
        odqn_reg   <= odqn_next;
        obbr_reg   <= obbr_next;
    end

    assign out_valid        = ovalid_reg;
    assign seg_echo         = oseg_reg;
    assign is_measurement   = omeas_reg;
    assign srtt_out         = osrtt_reg;
    assign rttvar_out       = ovar_reg;
    assign rto_out          = orto_reg;
    assign dqn_interval_out = odqn_reg;
    assign bbr_interval_out = obbr_reg;

endmodule

// ===== hdl/rre_serial_div.sv =====
// ----------------------------------------------------------------------------
// rre_serial_div
// Restoring divider, one quotient bit per cycle: gain / sample count.
// ----------------------------------------------------------------------------
module rre_serial_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rre_pkg::GAIN_W-1:0] dividend,
    input  logic [rre_pkg::CNT_W-1:0]  divisor,
    output logic [rre_pkg::GAIN_W-1:0] quotient,
    output logic                       done
);
    import rre_pkg::*;

    logic                busy_reg,  busy_next;
    logic                done_reg,  done_next;
    logic [3:0]          cnt_reg,   cnt_next;
    logic [GAIN_W-1:0]   q_reg,     q_next;
    logic [CNT_W-1:0]    rem_reg,   rem_next;
    logic [CNT_W-1:0]    dvs_reg,   dvs_next;
    logic [CNT_W:0]      trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, q_reg[GAIN_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = CNT_W'(trial - {1'b0, dvs_reg});
                q_next   = {q_reg[GAIN_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[CNT_W-1:0];
                q_next   = {q_reg[GAIN_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

// ===== hdl/rre_serial_mac.sv =====
// ----------------------------------------------------------------------------
// rre_serial_mac
// Shift-and-add multiply-accumulate, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rre_serial_mac (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rre_pkg::mac_cmd_t         cmd,
    output logic [rre_pkg::ACC_W-1:0] acc,
    output logic                      done
);
    import rre_pkg::*;

    logic                busy_reg,  busy_next;
    logic                done_reg,  done_next;
    logic [3:0]          cnt_reg,   cnt_next;
    logic [ACC_W-1:0]    acc_reg,   acc_next;
    logic [ACC_W-1:0]    mcand_reg, mcand_next;
    logic [GAIN_W-1:0]   mult_reg,  mult_next;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        mult_next  = mult_reg;
        if (cmd.start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            acc_next   = cmd.acc_init;
            mcand_next = cmd.mcand;
            mult_next  = cmd.mult;
        end
        else if (busy_reg)
        begin
            // add the weighted multiplicand when the current bit is set
            if (mult_reg[0])
                acc_next = acc_reg + mcand_reg;
            mcand_next = {mcand_reg[ACC_W-2:0], 1'b0};
            mult_next  = {1'b0, mult_reg[GAIN_W-1:1]};
            cnt_next   = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        mult_reg  <= mult_next;
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule
